FILE: src/fsp_pkg.sv
`default_nettype none
package fsp_pkg;

  // Largest point count that the lattice honors; a larger count is clamped.
  localparam int MAX_POINTS = 4096;

  localparam int IDX_W  = 12;
  localparam int CNT_W  = 13;
  localparam int RAD_W  = 16;
  localparam int COORD_W = 24;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPHERE_RADIUS = 2'd1;

  localparam logic [CNT_W-1:0] POINT_COUNT_RST   = 13'd64;
  localparam logic [RAD_W-1:0] SPHERE_RADIUS_RST = 16'd256;

  // Golden angle in 2^-32 turns.
  localparam logic [31:0] GOLDEN_TURN = 32'd1640531527;

  localparam int CORDIC_STEPS = 24;
  localparam logic signed [32:0] CORDIC_START = 33'sd652032874;

  // Arctangent of 2^-k in 2^-32 turns.
  function automatic logic signed [32:0] atan_turn(input int k);
    logic signed [32:0] a;
    case (k)
      0:  a = 33'sd536870912;
      1:  a = 33'sd316933406;
      2:  a = 33'sd167458907;
      3:  a = 33'sd85004756;
      4:  a = 33'sd42667331;
      5:  a = 33'sd21354465;
      6:  a = 33'sd10679838;
      7:  a = 33'sd5340245;
      8:  a = 33'sd2670163;
      9:  a = 33'sd1335087;
      10: a = 33'sd667544;
      11: a = 33'sd333772;
      12: a = 33'sd166886;
      13: a = 33'sd83443;
      14: a = 33'sd41722;
      15: a = 33'sd20861;
      16: a = 33'sd10430;
      17: a = 33'sd5215;
      18: a = 33'sd2608;
      19: a = 33'sd1304;
      20: a = 33'sd652;
      21: a = 33'sd326;
      22: a = 33'sd163;
      23: a = 33'sd81;
      default: a = 33'sd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

FILE: src/fibonacci_sphere_point.sv
`default_nettype none
// Fibonacci sphere lattice point generator.
// A request is taken on every clock edge at which start is high; busy is
// always low, so a new point index may be presented in every cycle.
// Each request yields exactly one result, shown for one cycle with
// out_strobe high.
// Throughput is one point per cycle: the divider, square root and CORDIC
// are fully pipelined, and the longest chain (input register, 8 divider
// stages, squaring, 8 square-root stages, two multiply stages) sets the
// latency. The receiver cannot stall, so nothing is ever held back.
// Configuration: cfg_wr_en with cfg_index 0 writes the point count
// (low 13 bits of cfg_data), index 1 the sphere radius in unsigned Q8.8.
// Other indexes are ignored. Write only while no request is in flight.
// Reset sets the point count to 64, the radius to 1.0 and empties the
// pipeline; no strobe appears until a new request is taken.
// An index at or above the point count returns zero coordinates with
// out_index_error set.
module fibonacci_sphere_point (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [fsp_pkg::IDX_W-1:0]     in_point_index,
  input  wire logic                          cfg_wr_en,
  input  wire logic [fsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fsp_pkg::RAD_W-1:0]     cfg_data,
  output logic                               out_strobe,
  output logic signed [fsp_pkg::COORD_W-1:0] out_coord_x,
  output logic signed [fsp_pkg::COORD_W-1:0] out_coord_y,
  output logic signed [fsp_pkg::COORD_W-1:0] out_coord_z,
  output logic                               out_index_error
);
  import fsp_pkg::*;

  // Stage bookkeeping: the input register is stage 0, the output register 19.
  localparam int LAT    = 19;
  localparam int CS_DLY = 3;  // CORDIC is ready ahead of the root
  localparam int Y_DLY  = 8;  // height waits out the square root

  logic [CNT_W-1:0] cnt_r;
  logic [RAD_W-1:0] rad_r;
  logic [CNT_W-1:0] cnt_eff;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= POINT_COUNT_RST;
      rad_r <= SPHERE_RADIUS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_POINT_COUNT:   cnt_r <= cfg_data[CNT_W-1:0];
        REG_SPHERE_RADIUS: rad_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cnt_eff = (32'(cnt_r) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : cnt_r;
  assign busy    = 1'b0;

  // Stage 0: input register.
  logic [IDX_W-1:0] idx_r;
  logic             err0;
  logic             vld_r [LAT];
  logic             err_r [LAT];

  assign err0 = ({1'b0, in_point_index} >= cnt_eff);

  always_ff @(posedge clk) begin
    idx_r <= in_point_index;
  end

  // Valid and error flags travel alongside the data through every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      vld_r[0] <= start;
      for (int k = 1; k < LAT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    err_r[0] <= err0;
    for (int k = 1; k < LAT; k++) begin
      err_r[k] <= err_r[k-1];
    end
  end

  // Height: quotient of (2i+1)*2^16 + n by 2n, rounded half up.
  logic [15:0] quot;

  fsp_div u_div (
    .clk      (clk),
    .in_num_hi({1'b0, idx_r, 1'b1}),
    .in_cnt   (cnt_eff),
    .out_quot (quot)
  );

  // Stage 9: recenter the height and square it.
  logic signed [15:0] hgt_r;
  logic [31:0]        hsq_r;
  logic signed [15:0] hgt_d [Y_DLY];
  logic [30:0]        sq_in;
  logic signed [31:0] hgt_x;

  // The height sign-extended to the full width of its square.
  assign hgt_x = 32'($signed({~quot[15], quot[14:0]}));

  always_ff @(posedge clk) begin
    hgt_r <= $signed({~quot[15], quot[14:0]});
    hsq_r <= hgt_x * hgt_x;
  end

  assign sq_in = 31'(32'h4000_0000 - hsq_r);

  logic [15:0] root;

  fsp_sqrt u_sqrt (
    .clk     (clk),
    .in_val  (sq_in),
    .out_root(root)
  );

  always_ff @(posedge clk) begin
    hgt_d[0] <= hgt_r;
    for (int k = 1; k < Y_DLY; k++) begin
      hgt_d[k] <= hgt_d[k-1];
    end
  end

  // Angle path, in parallel with the height path.
  logic signed [16:0] cs_cos;
  logic signed [16:0] cs_sin;
  logic signed [16:0] cos_d [CS_DLY];
  logic signed [16:0] sin_d [CS_DLY];

  fsp_cordic u_cordic (
    .clk     (clk),
    .in_index(idx_r),
    .out_cos (cs_cos),
    .out_sin (cs_sin)
  );

  always_ff @(posedge clk) begin
    cos_d[0] <= cs_cos;
    sin_d[0] <= cs_sin;
    for (int k = 1; k < CS_DLY; k++) begin
      cos_d[k] <= cos_d[k-1];
      sin_d[k] <= sin_d[k-1];
    end
  end

  // Stage 18: ring radius times cos and sin, height times sphere radius.
  logic signed [31:0] rc_r;
  logic signed [31:0] rs_r;
  logic signed [32:0] yr_r;
  logic signed [16:0] rad_s;

  assign rad_s = $signed({1'b0, rad_r});

  // Operands are widened first so the products keep all their bits.
  always_ff @(posedge clk) begin
    rc_r <= 32'($signed({1'b0, root})) * 32'(cos_d[CS_DLY-1]);
    rs_r <= 32'($signed({1'b0, root})) * 32'(sin_d[CS_DLY-1]);
    yr_r <= 33'(hgt_d[Y_DLY-1]) * 33'(rad_s);
  end

  // Stage 19: scale by the sphere radius, round, and zero on error.
  logic signed [48:0] px;
  logic signed [48:0] pz;
  logic signed [33:0] py;

  assign px = 49'(rc_r) * 49'(rad_s) + 49'sd4194304;
  assign pz = 49'(rs_r) * 49'(rad_s) + 49'sd4194304;
  assign py = 34'(yr_r) + 34'sd128;

  logic                      strobe_r;
  logic                      oerr_r;
  logic signed [COORD_W-1:0] ox_r;
  logic signed [COORD_W-1:0] oy_r;
  logic signed [COORD_W-1:0] oz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    oerr_r <= err_r[LAT-1];
    if (err_r[LAT-1]) begin
      ox_r <= '0;
      oy_r <= '0;
      oz_r <= '0;
    end else begin
      ox_r <= px[46:23];
      oy_r <= py[31:8];
      oz_r <= pz[46:23];
    end
  end

  assign out_strobe      = strobe_r;
  assign out_index_error = oerr_r;
  assign out_coord_x     = ox_r;
  assign out_coord_y     = oy_r;
  assign out_coord_z     = oz_r;

endmodule
`default_nettype wire

FILE: src/fsp_div.sv
`default_nettype none
// Restoring divider, two quotient bits per stage. The dividend is
// (num_hi * 2^16 + cnt) and the divisor 2 * cnt; the quotient is below 2^16.
module fsp_div (
  input  wire logic                     clk,
  input  wire logic [13:0]              in_num_hi,
  input  wire logic [fsp_pkg::CNT_W-1:0] in_cnt,
  output logic      [15:0]              out_quot
);
  import fsp_pkg::*;

  localparam int STG = 8;

  logic [13:0] rem_r [STG];
  logic [15:0] quo_r [STG];
  logic [15:0] low;
  logic [13:0] dvs;

  assign low = {3'b000, in_cnt};
  assign dvs = {in_cnt, 1'b0};

  function automatic logic [14:0] div_step(input logic [13:0] rem, input logic b,
                                           input logic [13:0] d);
    logic [14:0] t;
    logic [14:0] res;
    t = {rem, b};
    if (t >= {1'b0, d}) begin
      res = {1'b1, 14'(t - {1'b0, d})};
    end else begin
      res = {1'b0, t[13:0]};
    end
    return res;
  endfunction

  genvar s;
  generate
    for (s = 0; s < STG; s++) begin : g_stg
      logic [13:0] rem_in;
      logic [15:0] quo_in;
      logic [14:0] st_a;
      logic [14:0] st_b;
      if (s == 0) begin : g_first
        assign rem_in = in_num_hi;
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem_r[s-1];
        assign quo_in = quo_r[s-1];
      end
      assign st_a = div_step(rem_in, low[15-2*s], dvs);
      assign st_b = div_step(st_a[13:0], low[14-2*s], dvs);
      always_ff @(posedge clk) begin
        rem_r[s] <= st_b[13:0];
        quo_r[s] <= {quo_in[13:0], st_a[14], st_b[14]};
      end
    end
  endgenerate

  assign out_quot = quo_r[STG-1];

endmodule
`default_nettype wire

FILE: src/fsp_sqrt.sv
`default_nettype none
// Digit-by-digit integer square root, two root bits per stage.
module fsp_sqrt (
  input  wire logic        clk,
  input  wire logic [30:0] in_val,
  output logic      [15:0] out_root
);
  import fsp_pkg::*;

  localparam int STG = 8;

  logic [31:0] val_r  [STG];
  logic [17:0] rem_r  [STG];
  logic [15:0] root_r [STG];

  function automatic logic [33:0] sq_step(input logic [17:0] rem, input logic [1:0] pair,
                                          input logic [15:0] root);
    logic [19:0] t;
    logic [19:0] trial;
    logic [33:0] res;
    t     = {rem, pair};
    trial = {2'b00, root, 2'b01};
    if (t >= trial) begin
      res = {18'(t - trial), root[14:0], 1'b1};
    end else begin
      res = {t[17:0], root[14:0], 1'b0};
    end
    return res;
  endfunction

  genvar s;
  generate
    for (s = 0; s < STG; s++) begin : g_stg
      logic [31:0] val_in;
      logic [17:0] rem_in;
      logic [15:0] root_in;
      logic [33:0] st_a;
      logic [33:0] st_b;
      if (s == 0) begin : g_first
        assign val_in  = {1'b0, in_val};
        assign rem_in  = '0;
        assign root_in = '0;
      end else begin : g_next
        assign val_in  = val_r[s-1];
        assign rem_in  = rem_r[s-1];
        assign root_in = root_r[s-1];
      end
      assign st_a = sq_step(rem_in, val_in[31:30], root_in);
      assign st_b = sq_step(st_a[33:16], val_in[29:28], st_a[15:0]);
      always_ff @(posedge clk) begin
        val_r[s]  <= {val_in[27:0], 4'b0000};
        rem_r[s]  <= st_b[33:16];
        root_r[s] <= st_b[15:0];
      end
    end
  endgenerate

  assign out_root = root_r[STG-1];

endmodule
`default_nettype wire

FILE: src/fsp_cordic.sv
`default_nettype none
// Golden-angle phase, then a rotation-mode CORDIC with two micro-rotations
// per stage, then rounding to Q1.15 and the quadrant fold.
module fsp_cordic (
  input  wire logic                      clk,
  input  wire logic [fsp_pkg::IDX_W-1:0] in_index,
  output logic signed [16:0]             out_cos,
  output logic signed [16:0]             out_sin
);
  import fsp_pkg::*;

  localparam int STG = CORDIC_STEPS / 2;

  logic [31:0]        phi_r;
  logic signed [32:0] x_r [STG];
  logic signed [32:0] y_r [STG];
  logic signed [32:0] z_r [STG];
  logic [1:0]         quad_r [STG];
  logic signed [16:0] cc;
  logic signed [16:0] ss;
  logic signed [16:0] cos_r;
  logic signed [16:0] sin_r;

  always_ff @(posedge clk) begin
    phi_r <= 32'({20'd0, in_index} * GOLDEN_TURN);
  end

  function automatic logic signed [16:0] to_q15(input logic signed [32:0] v);
    logic signed [33:0] t;
    logic signed [16:0] res;
    t = (34'(v) + 34'sd16384) >>> 15;
    if (t > 34'sd32768) begin
      res = 17'sd32768;
    end else if (t < -34'sd32768) begin
      res = -17'sd32768;
    end else begin
      res = 17'(t);
    end
    return res;
  endfunction

  genvar s;
  generate
    for (s = 0; s < STG; s++) begin : g_stg
      logic signed [32:0] x_in, y_in, z_in;
      logic signed [32:0] x_a, y_a, z_a;
      logic signed [32:0] x_b, y_b, z_b;
      logic [1:0]         quad_in;
      if (s == 0) begin : g_first
        assign x_in    = CORDIC_START;
        assign y_in    = '0;
        assign z_in    = {3'b000, phi_r[29:0]};
        assign quad_in = phi_r[31:30];
      end else begin : g_next
        assign x_in    = x_r[s-1];
        assign y_in    = y_r[s-1];
        assign z_in    = z_r[s-1];
        assign quad_in = quad_r[s-1];
      end
      always_comb begin
        if (z_in >= 0) begin
          x_a = x_in - (y_in >>> (2*s));
          y_a = y_in + (x_in >>> (2*s));
          z_a = z_in - atan_turn(2*s);
        end else begin
          x_a = x_in + (y_in >>> (2*s));
          y_a = y_in - (x_in >>> (2*s));
          z_a = z_in + atan_turn(2*s);
        end
        if (z_a >= 0) begin
          x_b = x_a - (y_a >>> (2*s+1));
          y_b = y_a + (x_a >>> (2*s+1));
          z_b = z_a - atan_turn(2*s+1);
        end else begin
          x_b = x_a + (y_a >>> (2*s+1));
          y_b = y_a - (x_a >>> (2*s+1));
          z_b = z_a + atan_turn(2*s+1);
        end
      end
      always_ff @(posedge clk) begin
        x_r[s]    <= x_b;
        y_r[s]    <= y_b;
        z_r[s]    <= z_b;
        quad_r[s] <= quad_in;
      end
    end
  endgenerate

  assign cc = to_q15(x_r[STG-1]);
  assign ss = to_q15(y_r[STG-1]);

  always_ff @(posedge clk) begin
    case (quad_r[STG-1])
      2'd0: begin
        cos_r <= cc;
        sin_r <= ss;
      end
      2'd1: begin
        cos_r <= -ss;
        sin_r <= cc;
      end
      2'd2: begin
        cos_r <= -cc;
        sin_r <= -ss;
      end
      default: begin
        cos_r <= ss;
        sin_r <= -cc;
      end
    endcase
  end

  assign out_cos = cos_r;
  assign out_sin = sin_r;

endmodule
`default_nettype wire
